// ===== rtl/tsrb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsrb_pkg: shared types and constants
// Sizes, limits, command and status codes of the segment reorder buffer.
// ----------------------------------------------------------------------------
package tsrb_pkg;

  localparam int unsigned ENTRIES = 64;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [31:0] FAR_LIMIT    = 32'd10485760;
  localparam logic [15:0] HOLE_CAP     = 16'd65495;
  localparam logic [30:0] BUDGET_RESET = 31'd1048576;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_FAST = 3'd1,
    CMD_GET  = 3'd2,
    CMD_ACK  = 3'd3,
    CMD_END  = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_STORED    = 4'd0,
    ST_STALE     = 4'd1,
    ST_OVL_NEXT  = 4'd2,
    ST_SAME_SEQ  = 4'd3,
    ST_OVL_PREV  = 4'd4,
    ST_FAR       = 4'd5,
    ST_FULL      = 4'd6,
    ST_FAST_OK   = 4'd7,
    ST_FAST_REF  = 4'd8,
    ST_DELIVERED = 4'd9,
    ST_FILLER    = 4'd10,
    ST_NONE      = 4'd11,
    ST_ACK_TAKEN = 4'd12,
    ST_ACK_SAME  = 4'd13,
    ST_ENDED     = 4'd14
  } status_t;

  // one descriptor as held in the store
  typedef struct packed {
    logic [31:0] seq;
    logic [15:0] length;
    logic [15:0] saved;
    logic [15:0] handle;
  } desc_t;

endpackage
`default_nettype wire

// ===== rtl/tsrb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsrb_store: descriptor memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsrb_store (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [tsrb_pkg::IDX_W-1:0]  wr_addr,
  input  wire tsrb_pkg::desc_t             wr_data,
  input  wire logic [tsrb_pkg::IDX_W-1:0]  rd_addr,
  output tsrb_pkg::desc_t                  rd_data
);

  tsrb_pkg::desc_t mem [tsrb_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/tcp_segment_reorder_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_segment_reorder_buffer: TCP out-of-order segment descriptor buffer
// Sorted descriptor store with add, fast add, get, ack and end commands.
// ----------------------------------------------------------------------------
// One transaction at a time; the next transaction is taken only once the
// result has been taken. Fast add, ack, end, unknown commands, a get on an
// empty store and an add dropped as stale or after session end go from the
// decode state straight to the result; a get that fills a hole or has
// nothing to deliver passes through the get state first; a get that delivers
// the front then compacts the store through its write and read ports.
// An add scans the sorted store one descriptor per cycle through the memory
// read port, then moves the tail up one slot per cycle and inserts the new
// descriptor; an add refused during or after the scan ends there. The
// result is held in an output register until it is taken.
module tcp_segment_reorder_buffer (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [31:0] seq_number,
  input  wire logic [15:0] payload_length,
  input  wire logic [15:0] saved_length,
  input  wire logic [15:0] packet_handle,
  input  wire logic [31:0] ack_value,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [30:0] cfg_data,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       status,
  output logic             accepted,
  output logic [31:0]      out_seq,
  output logic [15:0]      out_length,
  output logic [15:0]      out_saved_length,
  output logic [15:0]      out_handle,
  output logic             buffer_nonempty,
  output logic [31:0]      next_expected
);

  localparam int unsigned IW = tsrb_pkg::IDX_W;
  localparam int unsigned CW = tsrb_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_CHECK = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_INS   = 9'b000100000,
    S_GET   = 9'b001000000,
    S_COMP  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // held transaction
  logic [2:0]  cmd_r;
  logic [31:0] seq_r;
  logic [15:0] len_r, sv_r, hdl_r;
  logic [31:0] ack_r;

  // block state
  logic [CW-1:0] entry_count;
  logic [31:0]   next_seq, highest_ack, bytes_held;
  logic          have_first, session_alive;
  logic [30:0]   byte_budget;

  // walk state
  logic [CW-1:0] idx;        // scan / shift position
  logic          rd_pend;    // read data valid for idx
  logic [31:0]   prev_seq;
  logic [32:0]   prev_end;
  logic          prev_any;

  // memory port
  logic               wr_en;
  logic [IW-1:0]      wr_addr, rd_addr;
  tsrb_pkg::desc_t    wr_data, rd_data;

  tsrb_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared compare unit: one descriptor against the held segment
  logic [32:0] seg_end, ent_end;
  assign seg_end = {1'b0, seq_r} + {17'd0, len_r};
  assign ent_end = {1'b0, rd_data.seq} + {17'd0, rd_data.length};

  logic [31:0] nxt_plus;
  logic        nxt_ovf;
  logic [15:0] adv_amt;
  logic [32:0] adv_sum;
  assign adv_sum  = {1'b0, next_seq} + {17'd0, adv_amt};
  assign nxt_ovf  = adv_sum[32];
  assign nxt_plus = nxt_ovf ? next_seq : adv_sum[31:0];

  // filler hole length
  logic [31:0] hole_a, hole_b, hole_m;
  always_comb begin
    hole_a = (next_seq < highest_ack) ? (highest_ack - next_seq) : 32'hFFFF_FFFF;
    hole_b = rd_data.seq - next_seq;
    hole_m = (hole_b < hole_a) ? hole_b : hole_a;
  end
  logic [15:0] hole;
  assign hole = (hole_m > {16'd0, tsrb_pkg::HOLE_CAP}) ? tsrb_pkg::HOLE_CAP : hole_m[15:0];

  assign in_stall  = (state != S_IDLE) || out_valid;
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign buffer_nonempty = (entry_count != '0);
  assign next_expected   = next_seq;

  // advance amount mux
  always_comb begin
    adv_amt = len_r;
    if (state == S_GET) begin
      adv_amt = (rd_data.seq == next_seq) ? rd_data.length : hole;
    end
  end

  // memory addressing
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx[IW-1:0];
    wr_data = rd_data;
    rd_addr = idx[IW-1:0];
    case (state)
      S_SCAN: begin
        // fetch the following entry for the next scan step
        rd_addr = IW'(idx + CW'(1));
      end
      S_SHIFT: begin
        wr_en   = rd_pend;
        wr_addr = IW'(idx + CW'(1));
        rd_addr = IW'(idx - CW'(1));
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_data = '{seq: seq_r, length: len_r, saved: sv_r, handle: hdl_r};
      end
      S_COMP: begin
        wr_en   = rd_pend;
        wr_addr = IW'(idx - CW'(2));
        rd_addr = idx[IW-1:0];
      end
      default: ;
    endcase
  end

  // result staging
  task automatic post(input tsrb_pkg::status_t st, input logic acc);
    status   <= st;
    accepted <= acc;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      entry_count   <= '0;
      next_seq      <= '0;
      highest_ack   <= '0;
      bytes_held    <= '0;
      have_first    <= 1'b0;
      session_alive <= 1'b1;
      byte_budget   <= tsrb_pkg::BUDGET_RESET;
      idx           <= '0;
      rd_pend       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        byte_budget <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd_r <= command; seq_r <= seq_number; len_r <= payload_length;
            sv_r  <= saved_length; hdl_r <= packet_handle; ack_r <= ack_value;
            idx   <= '0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          // rd_data now holds entry 0
          out_seq <= '0; out_length <= '0; out_saved_length <= '0; out_handle <= '0;
          case (cmd_r)
            tsrb_pkg::CMD_ADD: begin
              if (!session_alive) begin
                post(tsrb_pkg::ST_ENDED, 1'b0);
                state <= S_DONE;
              end else if (have_first && seq_r < next_seq) begin
                post(tsrb_pkg::ST_STALE, 1'b1);
                state <= S_DONE;
              end else begin
                idx      <= '0;
                rd_pend  <= 1'b1;
                prev_any <= 1'b0;
                state    <= S_SCAN;
              end
            end
            tsrb_pkg::CMD_FAST: begin
              state <= S_DONE;
              if (!session_alive) begin
                post(tsrb_pkg::ST_ENDED, 1'b0);
              end else if ((have_first && seq_r < next_seq) ||
                           (entry_count != '0 &&
                            (seq_r >= rd_data.seq || seg_end > {1'b0, rd_data.seq})) ||
                           (len_r != sv_r) ||
                           (have_first && seq_r != next_seq)) begin
                post(tsrb_pkg::ST_FAST_REF, 1'b0);
              end else begin
                // next_seq becomes seq_r (equal when have_first), then advances
                if (({1'b0, seq_r} + {17'd0, len_r}) <= 33'h0_FFFF_FFFF) begin
                  next_seq <= seq_r + {16'd0, len_r};
                end else begin
                  next_seq <= seq_r;
                end
                have_first <= 1'b1;
                post(tsrb_pkg::ST_FAST_OK, 1'b1);
              end
            end
            tsrb_pkg::CMD_GET: begin
              if (entry_count == '0) begin
                post(tsrb_pkg::ST_NONE, 1'b0);
                state <= S_DONE;
              end else begin
                state <= S_GET;
              end
            end
            tsrb_pkg::CMD_ACK: begin
              state <= S_DONE;
              if (highest_ack < ack_r &&
                  !((ack_r - highest_ack) > tsrb_pkg::FAR_LIMIT &&
                    next_seq < ack_r && (ack_r - next_seq) > tsrb_pkg::FAR_LIMIT)) begin
                highest_ack <= ack_r;
                post(tsrb_pkg::ST_ACK_TAKEN, 1'b0);
              end else begin
                post(tsrb_pkg::ST_ACK_SAME, 1'b0);
              end
            end
            tsrb_pkg::CMD_END: begin
              session_alive <= 1'b0;
              post(tsrb_pkg::ST_ENDED, 1'b0);
              state <= S_DONE;
            end
            default: begin
              post(tsrb_pkg::ST_NONE, 1'b0);
              state <= S_DONE;
            end
          endcase
        end
        // walk sorted entries, one per cycle (read data is for entry idx)
        S_SCAN: begin
          if (idx == entry_count) begin
            state <= S_CHECK;
          end else if (seq_r < rd_data.seq) begin
            if (seg_end > {1'b0, rd_data.seq}) begin
              post(tsrb_pkg::ST_OVL_NEXT, 1'b1);
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end else if (seq_r == rd_data.seq) begin
            post(tsrb_pkg::ST_SAME_SEQ, 1'b1);
            state <= S_DONE;
          end else begin
            prev_any <= 1'b1;
            prev_seq <= rd_data.seq;
            prev_end <= ent_end;
            idx      <= idx + CW'(1);
          end
        end
        S_CHECK: begin
          if (prev_any && prev_end > {1'b0, seq_r}) begin
            post(tsrb_pkg::ST_OVL_PREV, 1'b1);
            state <= S_DONE;
          end else if ((seq_r - (prev_any ? prev_seq : next_seq)) > tsrb_pkg::FAR_LIMIT) begin
            post(tsrb_pkg::ST_FAR, 1'b1);
            state <= S_DONE;
          end else if (bytes_held > {1'b0, byte_budget} ||
                       entry_count >= CW'(tsrb_pkg::ENTRIES)) begin
            post(tsrb_pkg::ST_FULL, 1'b0);
            state <= S_DONE;
          end else begin
            // move tail up: read entry_count-1 first
            rd_pend <= 1'b0;
            prev_seq <= {{(32-CW){1'b0}}, idx};  // insert point kept here
            idx   <= entry_count;
            state <= S_SHIFT;
          end
        end
        // idx: slot whose entry was read last cycle when rd_pend; it moves to idx+1
        S_SHIFT: begin
          if (rd_pend) begin
            // wrote entry idx -> idx+1 this cycle
          end
          if (idx == prev_seq[CW-1:0]) begin
            state <= S_INS;
          end else begin
            rd_pend <= 1'b1;
            idx     <= idx - CW'(1);
          end
        end
        S_INS: begin
          entry_count <= entry_count + CW'(1);
          bytes_held  <= bytes_held + {16'd0, sv_r};
          if (!have_first) begin
            next_seq   <= seq_r;
            have_first <= 1'b1;
          end
          post(tsrb_pkg::ST_STORED, 1'b1);
          state <= S_DONE;
        end
        // rd_data holds front entry
        S_GET: begin
          if (rd_data.seq == next_seq) begin
            out_seq <= rd_data.seq; out_length <= rd_data.length;
            out_saved_length <= rd_data.saved; out_handle <= rd_data.handle;
            next_seq   <= nxt_plus;
            bytes_held <= (bytes_held >= {16'd0, rd_data.saved}) ?
                          bytes_held - {16'd0, rd_data.saved} : '0;
            entry_count <= entry_count - CW'(1);
            post(tsrb_pkg::ST_DELIVERED, 1'b0);
            idx     <= CW'(1);
            rd_pend <= 1'b0;
            state   <= S_COMP;
          end else if (!session_alive || {1'b0, byte_budget} < bytes_held ||
                       next_seq < highest_ack) begin
            out_seq <= next_seq; out_length <= hole;
            out_saved_length <= '0; out_handle <= rd_data.handle;
            next_seq <= nxt_plus;
            post(tsrb_pkg::ST_FILLER, 1'b0);
            state <= S_DONE;
          end else begin
            post(tsrb_pkg::ST_NONE, 1'b0);
            state <= S_DONE;
          end
        end
        // move entries down: read idx, write previous read at idx-2
        S_COMP: begin
          if (idx > entry_count) begin
            if (rd_pend) begin
              idx <= idx + CW'(1);
              rd_pend <= 1'b0;
            end else begin
              state <= S_DONE;
            end
          end else begin
            rd_pend <= 1'b1;
            idx     <= idx + CW'(1);
          end
        end
        // park the read port on entry 0 for the next transaction
        S_DONE: begin
          out_valid <= 1'b1;
          idx       <= '0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
